// ===== rtl/core/i2cs_pkg.sv =====
`timescale 1ns / 1ps

package i2cs_pkg;

  localparam int PAGE_BYTES = 64;
  localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int ADDR_BITS  = 15;
  localparam int MAX_RES    = 4;
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_BYTE  = 2'd3;

  // read types
  localparam logic [1:0] RT_CURRENT = 2'd0;
  localparam logic [1:0] RT_RANDOM  = 2'd1;
  localparam logic [1:0] RT_SEQ     = 2'd2;
  localparam logic [1:0] RT_BAD     = 2'd3;

  // bus actions
  localparam logic [3:0] ACT_START   = 4'd0;
  localparam logic [3:0] ACT_SEND    = 4'd1;
  localparam logic [3:0] ACT_CLRADDR = 4'd2;
  localparam logic [3:0] ACT_ACK     = 4'd3;
  localparam logic [3:0] ACT_NACK    = 4'd4;
  localparam logic [3:0] ACT_STOP    = 4'd5;
  localparam logic [3:0] ACT_PROTECT = 4'd6;
  localparam logic [3:0] ACT_RXDATA  = 4'd7;
  localparam logic [3:0] ACT_DONE    = 4'd8;

  // final status
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BUSY  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_BYTE  = 3'd4;
  localparam logic [2:0] ST_RX    = 3'd5;
  localparam logic [2:0] ST_BADRQ = 3'd6;

  // configuration register indexes
  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic [7:0] DEV_ADDR_RST = 8'd160;
  localparam logic [7:0] TIMEOUT_RST  = 8'd100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [14:0] mem_address;
    logic [7:0]  data_amount;
    logic [1:0]  read_type;
    logic [7:0]  write_byte;
    logic        flag_busy;
    logic        flag_start_sent;
    logic        flag_addr_acked;
    logic        flag_byte_done;
    logic        flag_rx_ready;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] tx_value;
    logic [7:0] rx_data;
    logic       protect_level;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]       count;
    out_item_t [MAX_RES-1:0]    items;
  } res_bundle_t;

  function automatic out_item_t mk_res(logic [3:0] act, logic [7:0] tx, logic [7:0] rx,
                                       logic prot, logic [2:0] st);
    out_item_t r;
    r.action        = act;
    r.tx_value      = tx;
    r.rx_data       = rx;
    r.protect_level = prot;
    r.status        = st;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/i2c_eeprom_transaction_sequencer.sv =====
`timescale 1ns / 1ps

// Master-side sequencer for a 15-bit-addressed I2C EEPROM. Each request
// (begin write, begin read, flag sample, write byte) is registered, worked
// on, and yields zero to three bus actions that leave through an
// eight-entry result queue, one per cycle while out_stall_i is low. A
// request is taken every cycle as long as no more than four results are
// still queued, so the input side sustains one request per clock when the
// output drains as fast as results are made. Registers: index 0 control
// byte (reset 160), index 1 timeout in ticks (reset 100). The user must
// write them only while no transaction is under way (not enforced here).
module i2c_eeprom_transaction_sequencer import i2cs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  logic        in_vld_q;
  in_item_t    item_q;
  logic        fire, accept, room;
  res_bundle_t res;

  assign fire       = in_vld_q & room;
  assign in_stall_o = in_vld_q & ~room;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept | (in_vld_q & ~fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  i2cs_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .res_o       (res)
  );

  i2cs_rqueue u_rqueue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/i2cs_step.sv =====
`timescale 1ns / 1ps

module i2cs_step import i2cs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        fire_i,
  input  in_item_t    item_i,
  output res_bundle_t res_o
);

  localparam logic [4:0] P_IDLE    = 5'd0;
  localparam logic [4:0] P_W_BUSY  = 5'd1;
  localparam logic [4:0] P_W_SB    = 5'd2;
  localparam logic [4:0] P_W_ADDR  = 5'd3;
  localparam logic [4:0] P_W_HI    = 5'd4;
  localparam logic [4:0] P_W_LO    = 5'd5;
  localparam logic [4:0] P_W_NEED  = 5'd6;
  localparam logic [4:0] P_W_DATA  = 5'd7;
  localparam logic [4:0] P_R_BUSY  = 5'd8;
  localparam logic [4:0] P_R_SB1   = 5'd9;
  localparam logic [4:0] P_R_ADDR1 = 5'd10;
  localparam logic [4:0] P_R_HI    = 5'd11;
  localparam logic [4:0] P_R_LO    = 5'd12;
  localparam logic [4:0] P_R_SB2   = 5'd13;
  localparam logic [4:0] P_R_ADDR2 = 5'd14;
  localparam logic [4:0] P_R_RX    = 5'd15;

  logic [7:0]           dev_addr_q, timeout_q;
  logic [4:0]           phase_q, phase_d;
  logic [ADDR_BITS-1:0] cur_addr_q, cur_addr_d;
  logic [7:0]           byte_cnt_q, byte_cnt_d;
  logic [2:0]           pages_q, pages_d;
  logic [7:0]           amount_q, amount_d;
  logic [1:0]           rtype_q, rtype_d;
  logic [7:0]           ticks_q, ticks_d;

  out_item_t [MAX_RES-1:0] res;
  logic [RES_CNT_W-1:0]    n;
  logic                    active, ok;
  logic [2:0]              err;
  logic [7:0]              bc_inc;
  logic [8:0]              bc_inc_p1;
  logic [2:0]              pages_dec;
  logic [7:0]              addr_hi, addr_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEV_ADDR: dev_addr_q <= cfg_wdata_i;
        CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= P_IDLE;
      cur_addr_q <= '0;
      byte_cnt_q <= '0;
      pages_q    <= '0;
      amount_q   <= '0;
      rtype_q    <= '0;
      ticks_q    <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      cur_addr_q <= cur_addr_d;
      byte_cnt_q <= byte_cnt_d;
      pages_q    <= pages_d;
      amount_q   <= amount_d;
      rtype_q    <= rtype_d;
      ticks_q    <= ticks_d;
    end
  end

  assign addr_hi   = 8'(cur_addr_q >> 8);
  assign addr_lo   = cur_addr_q[7:0];
  assign bc_inc    = byte_cnt_q + 8'd1;
  assign bc_inc_p1 = {1'b0, bc_inc} + 9'd1;
  assign pages_dec = (pages_q != 3'd0) ? pages_q - 3'd1 : 3'd0;

  always_comb begin
    phase_d    = phase_q;
    cur_addr_d = cur_addr_q;
    byte_cnt_d = byte_cnt_q;
    pages_d    = pages_q;
    amount_d   = amount_q;
    rtype_d    = rtype_q;
    ticks_d    = ticks_q;
    res        = '0;
    n          = '0;
    active     = 1'b1;
    ok         = 1'b0;
    err        = ST_OK;

    case (item_i.cmd)
      CMD_WRITE: begin
        if (phase_q == P_IDLE) begin
          cur_addr_d = item_i.mem_address[ADDR_BITS-1:0];
          amount_d   = item_i.data_amount;
          pages_d    = (item_i.data_amount < 8'(PAGE_BYTES)) ? 3'd1
                       : 3'(item_i.data_amount >> PAGE_BITS);
          byte_cnt_d = '0;
          res[0]     = mk_res(ACT_PROTECT, 8'd0, 8'd0, 1'b0, ST_OK);
          n          = RES_CNT_W'(1);
          phase_d    = P_W_BUSY;
          ticks_d    = timeout_q;
        end
      end

      CMD_READ: begin
        if (phase_q == P_IDLE) begin
          if (item_i.read_type == RT_BAD ||
              (item_i.read_type != RT_SEQ && item_i.data_amount > 8'd1)) begin
            res[0] = mk_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_BADRQ);
            n      = RES_CNT_W'(1);
          end else begin
            cur_addr_d = item_i.mem_address[ADDR_BITS-1:0];
            amount_d   = item_i.data_amount;
            rtype_d    = item_i.read_type;
            byte_cnt_d = '0;
            phase_d    = P_R_BUSY;
            ticks_d    = timeout_q;
          end
        end
      end

      CMD_TICK: begin
        // which flag this phase waits on, and its error code
        case (phase_q)
          P_W_BUSY, P_R_BUSY: begin
            ok  = ~item_i.flag_busy;
            err = ST_BUSY;
          end
          P_W_SB, P_R_SB1, P_R_SB2: begin
            ok  = item_i.flag_start_sent;
            err = ST_START;
          end
          P_W_ADDR, P_R_ADDR1, P_R_ADDR2: begin
            ok  = item_i.flag_addr_acked;
            err = ST_ADDR;
          end
          P_W_HI, P_W_LO, P_W_DATA, P_R_HI, P_R_LO: begin
            ok  = item_i.flag_byte_done;
            err = ST_BYTE;
          end
          P_R_RX: begin
            ok  = item_i.flag_rx_ready;
            err = ST_RX;
          end
          default: active = 1'b0;
        endcase

        if (active && !ok) begin
          if (ticks_q != 8'd0) begin
            ticks_d = ticks_q - 8'd1;
          end else begin
            res[0]  = mk_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK);
            res[1]  = mk_res(ACT_DONE, 8'd0, 8'd0, 1'b0, err);
            n       = RES_CNT_W'(2);
            phase_d = P_IDLE;
          end
        end else if (active) begin
          ticks_d = timeout_q;
          case (phase_q)
            P_W_BUSY: begin
              res[0]  = mk_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_W_SB;
            end
            P_W_SB: begin
              res[0]  = mk_res(ACT_SEND, {dev_addr_q[7:1], 1'b0}, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_W_ADDR;
            end
            P_W_ADDR: begin
              res[0]  = mk_res(ACT_CLRADDR, 8'd0, 8'd0, 1'b0, ST_OK);
              res[1]  = mk_res(ACT_SEND, addr_hi, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(2);
              phase_d = P_W_HI;
            end
            P_W_HI: begin
              res[0]  = mk_res(ACT_SEND, addr_lo, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_W_LO;
            end
            P_W_LO: begin
              phase_d = P_W_NEED;
              ticks_d = ticks_q;
            end
            P_W_DATA: begin
              cur_addr_d = cur_addr_q + ADDR_BITS'(1);
              byte_cnt_d = bc_inc;
              if (bc_inc[PAGE_BITS-1:0] != '0) begin
                phase_d = P_W_NEED;
                ticks_d = ticks_q;
              end else begin
                // page boundary: close the page, raise write protect
                res[0]  = mk_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK);
                res[1]  = mk_res(ACT_PROTECT, 8'd0, 8'd0, 1'b1, ST_OK);
                pages_d = pages_dec;
                if (pages_dec == 3'd0) begin
                  res[2]  = mk_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_OK);
                  phase_d = P_IDLE;
                  ticks_d = ticks_q;
                end else begin
                  res[2]  = mk_res(ACT_PROTECT, 8'd0, 8'd0, 1'b0, ST_OK);
                  phase_d = P_W_BUSY;
                end
                n = RES_CNT_W'(3);
              end
            end
            P_R_BUSY: begin
              res[0]  = mk_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_R_SB1;
            end
            P_R_SB1: begin
              res[0]  = mk_res(ACT_SEND, {dev_addr_q[7:1], rtype_q == RT_CURRENT},
                               8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_R_ADDR1;
            end
            P_R_ADDR1, P_R_ADDR2: begin
              res[0] = mk_res(ACT_CLRADDR, 8'd0, 8'd0, 1'b0, ST_OK);
              if (phase_q == P_R_ADDR1 && rtype_q != RT_CURRENT) begin
                res[1]  = mk_res(ACT_SEND, addr_hi, 8'd0, 1'b0, ST_OK);
                n       = RES_CNT_W'(2);
                phase_d = P_R_HI;
              end else if (amount_q == 8'd0) begin
                res[1]  = mk_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK);
                res[2]  = mk_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_OK);
                n       = RES_CNT_W'(3);
                phase_d = P_IDLE;
                ticks_d = ticks_q;
              end else begin
                byte_cnt_d = '0;
                res[1]     = mk_res((amount_q == 8'd1) ? ACT_NACK : ACT_ACK,
                                    8'd0, 8'd0, 1'b0, ST_OK);
                n          = RES_CNT_W'(2);
                phase_d    = P_R_RX;
              end
            end
            P_R_HI: begin
              res[0]  = mk_res(ACT_SEND, addr_lo, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_R_LO;
            end
            P_R_LO: begin
              res[0]  = mk_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_R_SB2;
            end
            P_R_SB2: begin
              res[0]  = mk_res(ACT_SEND, {dev_addr_q[7:1], 1'b1}, 8'd0, 1'b0, ST_OK);
              n       = RES_CNT_W'(1);
              phase_d = P_R_ADDR2;
            end
            P_R_RX: begin
              res[0]     = mk_res(ACT_RXDATA, 8'd0, item_i.rx_byte, 1'b0, ST_OK);
              byte_cnt_d = bc_inc;
              if (bc_inc >= amount_q) begin
                res[1]  = mk_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK);
                res[2]  = mk_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_OK);
                n       = RES_CNT_W'(3);
                phase_d = P_IDLE;
                ticks_d = ticks_q;
              end else begin
                res[1] = mk_res((bc_inc_p1 == {1'b0, amount_q}) ? ACT_NACK : ACT_ACK,
                                8'd0, 8'd0, 1'b0, ST_OK);
                n      = RES_CNT_W'(2);
              end
            end
            default: ticks_d = ticks_q;
          endcase
        end
      end

      default: begin
        if (phase_q == P_W_NEED) begin
          res[0]  = mk_res(ACT_SEND, item_i.write_byte, 8'd0, 1'b0, ST_OK);
          n       = RES_CNT_W'(1);
          phase_d = P_W_DATA;
          ticks_d = timeout_q;
        end
      end
    endcase

    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (RES_CNT_W'(i + 1) == n);
    end
  end

  assign res_o.count = n;
  assign res_o.items = res;

endmodule

// ===== rtl/core/i2cs_rqueue.sv =====
`timescale 1ns / 1ps

module i2cs_rqueue import i2cs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  res_bundle_t res_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  localparam int DEPTH = 2 * MAX_RES;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] push_n;
  logic             pop;

  assign push_n      = push_i ? CNT_W'(res_i.count) : '0;
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // a whole burst of results must fit before the next request is taken
  assign room_o      = (cnt_q <= CNT_W'(DEPTH - MAX_RES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      cnt_q    <= cnt_q + push_n - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (push_i && CNT_W'(j) < push_n) begin
        mem_q[wr_ptr_q + PTR_W'(j)] <= res_i.items[j];
      end
    end
  end

endmodule

// ===== tb/tb_i2c_eeprom_transaction_sequencer.sv =====
`timescale 1ns / 1ps

module tb_i2c_eeprom_transaction_sequencer;
  import i2cs_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINTS    = 60;

  // flag vector order: {busy, start_sent, addr_acked, byte_done, rx_ready}
  localparam logic [4:0] FL_NONE  = 5'b00000;
  localparam logic [4:0] FL_BUSY  = 5'b10000;
  localparam logic [4:0] FL_START = 5'b01000;
  localparam logic [4:0] FL_ADDR  = 5'b00100;
  localparam logic [4:0] FL_BYTE  = 5'b00010;
  localparam logic [4:0] FL_RX    = 5'b00001;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_W_BUSY, PH_W_SB, PH_W_ADDR, PH_W_HI, PH_W_LO, PH_W_NEED, PH_W_DATA,
    PH_R_BUSY, PH_R_SB1, PH_R_ADDR1, PH_R_HI, PH_R_LO, PH_R_SB2, PH_R_ADDR2, PH_R_RX
  } seq_phase_e;

  // typed_cnt < 0: expectation comes from the sequencer model
  typedef struct {
    in_item_t  req;
    int        typed_cnt;
    out_item_t typed;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i;
  logic      cfg_index_i;
  logic [7:0] cfg_wdata_i;

  idle_mode_e idle_mode = IDLE_NONE;
  int         fail_count = 0;

  // sequencer model state
  seq_phase_e  ph;
  logic [14:0] cur_addr;
  logic [7:0]  xfer_cnt;
  logic [2:0]  pages_left;
  logic [7:0]  req_amt;
  logic [1:0]  rd_mode;
  logic [7:0]  ticks_left;
  logic [7:0]  dev_addr;
  logic [7:0]  tmo_ticks;

  out_item_t step_q[$];
  out_item_t bus_q[$];
  stim_row_t dir_rows[$];

  i2c_eeprom_transaction_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < MAX_PRINTS)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic out_item_t bus_res(logic [3:0] act, logic [7:0] tx, logic [7:0] rx,
                                        logic prot, logic [2:0] st, logic fin);
    out_item_t o;
    o.action        = act;
    o.tx_value      = tx;
    o.rx_data       = rx;
    o.protect_level = prot;
    o.status        = st;
    o.last          = fin;
    return o;
  endfunction

  function automatic logic [7:0] ctrl_byte(logic rw);
    return {dev_addr[7:1], rw};
  endfunction

  task automatic arm(seq_phase_e p);
    ph         = p;
    ticks_left = tmo_ticks;
  endtask

  task automatic start_rx();
    if (req_amt == 8'd0) begin
      step_q.push_back(bus_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
      step_q.push_back(bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
      ph = PH_IDLE;
    end else begin
      xfer_cnt = 8'd0;
      step_q.push_back(bus_res(req_amt == 8'd1 ? ACT_NACK : ACT_ACK, 8'd0, 8'd0, 1'b0, ST_OK,
                               1'b0));
      arm(PH_R_RX);
    end
  endtask

  task automatic flag_tick(in_item_t r);
    logic       ok;
    logic [2:0] err;
    ok  = 1'b0;
    err = ST_OK;
    case (ph)
      PH_W_BUSY, PH_R_BUSY: begin
        ok  = !r.flag_busy;
        err = ST_BUSY;
      end
      PH_W_SB, PH_R_SB1, PH_R_SB2: begin
        ok  = r.flag_start_sent;
        err = ST_START;
      end
      PH_W_ADDR, PH_R_ADDR1, PH_R_ADDR2: begin
        ok  = r.flag_addr_acked;
        err = ST_ADDR;
      end
      PH_W_HI, PH_W_LO, PH_W_DATA, PH_R_HI, PH_R_LO: begin
        ok  = r.flag_byte_done;
        err = ST_BYTE;
      end
      PH_R_RX: begin
        ok  = r.flag_rx_ready;
        err = ST_RX;
      end
      default: return;
    endcase
    if (!ok) begin
      if (ticks_left != 8'd0) begin
        ticks_left--;
      end else begin
        step_q.push_back(bus_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        step_q.push_back(bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, err, 1'b0));
        ph = PH_IDLE;
      end
      return;
    end
    case (ph)
      PH_W_BUSY: begin
        step_q.push_back(bus_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_W_SB);
      end
      PH_W_SB: begin
        step_q.push_back(bus_res(ACT_SEND, ctrl_byte(1'b0), 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_W_ADDR);
      end
      PH_W_ADDR: begin
        step_q.push_back(bus_res(ACT_CLRADDR, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        step_q.push_back(bus_res(ACT_SEND, {1'b0, cur_addr[14:8]}, 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_W_HI);
      end
      PH_W_HI: begin
        step_q.push_back(bus_res(ACT_SEND, cur_addr[7:0], 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_W_LO);
      end
      PH_W_LO: ph = PH_W_NEED;
      PH_W_DATA: begin
        cur_addr = cur_addr + 15'd1;  // wraps at full address space
        xfer_cnt = xfer_cnt + 8'd1;
        if ((xfer_cnt % PAGE_BYTES) != 0) begin
          ph = PH_W_NEED;
        end else begin
          step_q.push_back(bus_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
          step_q.push_back(bus_res(ACT_PROTECT, 8'd0, 8'd0, 1'b1, ST_OK, 1'b0));
          if (pages_left != 3'd0) pages_left--;
          if (pages_left == 3'd0) begin
            step_q.push_back(bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
            ph = PH_IDLE;
          end else begin
            step_q.push_back(bus_res(ACT_PROTECT, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
            arm(PH_W_BUSY);
          end
        end
      end
      PH_R_BUSY: begin
        step_q.push_back(bus_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_R_SB1);
      end
      PH_R_SB1: begin
        // current read goes straight to receive, so the first control byte reads
        step_q.push_back(bus_res(ACT_SEND, ctrl_byte(rd_mode == RT_CURRENT), 8'd0, 1'b0,
                                 ST_OK, 1'b0));
        arm(PH_R_ADDR1);
      end
      PH_R_ADDR1: begin
        step_q.push_back(bus_res(ACT_CLRADDR, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        if (rd_mode == RT_CURRENT) begin
          start_rx();
        end else begin
          step_q.push_back(bus_res(ACT_SEND, {1'b0, cur_addr[14:8]}, 8'd0, 1'b0, ST_OK,
                                   1'b0));
          arm(PH_R_HI);
        end
      end
      PH_R_HI: begin
        step_q.push_back(bus_res(ACT_SEND, cur_addr[7:0], 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_R_LO);
      end
      PH_R_LO: begin
        step_q.push_back(bus_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_R_SB2);
      end
      PH_R_SB2: begin
        step_q.push_back(bus_res(ACT_SEND, ctrl_byte(1'b1), 8'd0, 1'b0, ST_OK, 1'b0));
        arm(PH_R_ADDR2);
      end
      PH_R_ADDR2: begin
        step_q.push_back(bus_res(ACT_CLRADDR, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
        start_rx();
      end
      PH_R_RX: begin
        step_q.push_back(bus_res(ACT_RXDATA, 8'd0, r.rx_byte, 1'b0, ST_OK, 1'b0));
        xfer_cnt = xfer_cnt + 8'd1;
        if (xfer_cnt >= req_amt) begin
          step_q.push_back(bus_res(ACT_STOP, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
          step_q.push_back(bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
          ph = PH_IDLE;
        end else begin
          step_q.push_back(bus_res((xfer_cnt + 8'd1 == req_amt) ? ACT_NACK : ACT_ACK,
                                   8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
          arm(PH_R_RX);
        end
      end
      default: ;
    endcase
  endtask

  // Bus actions caused by one request; leaves them in step_q.
  task automatic predict_actions(in_item_t r);
    out_item_t tail;
    step_q.delete();
    case (r.cmd)
      CMD_WRITE: begin
        if (ph == PH_IDLE) begin
          cur_addr   = r.mem_address;
          req_amt    = r.data_amount;
          pages_left = (r.data_amount < PAGE_BYTES) ? 3'd1 : 3'(r.data_amount / PAGE_BYTES);
          xfer_cnt   = 8'd0;
          step_q.push_back(bus_res(ACT_PROTECT, 8'd0, 8'd0, 1'b0, ST_OK, 1'b0));
          arm(PH_W_BUSY);
        end
      end
      CMD_READ: begin
        if (ph == PH_IDLE) begin
          if (r.read_type == RT_BAD || (r.read_type != RT_SEQ && r.data_amount > 8'd1)) begin
            step_q.push_back(bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_BADRQ, 1'b0));
          end else begin
            cur_addr = r.mem_address;
            req_amt  = r.data_amount;
            rd_mode  = r.read_type;
            xfer_cnt = 8'd0;
            arm(PH_R_BUSY);
          end
        end
      end
      CMD_TICK: flag_tick(r);
      default: begin
        if (ph == PH_W_NEED) begin
          step_q.push_back(bus_res(ACT_SEND, r.write_byte, 8'd0, 1'b0, ST_OK, 1'b0));
          arm(PH_W_DATA);
        end
      end
    endcase
    if (step_q.size() != 0) begin
      tail      = step_q[step_q.size()-1];
      tail.last = 1'b1;
      step_q[step_q.size()-1] = tail;
    end
  endtask

  function automatic in_item_t req_of(logic [1:0] cmd, logic [14:0] addr, logic [7:0] amt,
                                      logic [1:0] rt, logic [7:0] wb, logic [4:0] fl,
                                      logic [7:0] rx);
    in_item_t r;
    r.cmd             = cmd;
    r.mem_address     = addr;
    r.data_amount     = amt;
    r.read_type       = rt;
    r.write_byte      = wb;
    r.flag_busy       = fl[4];
    r.flag_start_sent = fl[3];
    r.flag_addr_acked = fl[2];
    r.flag_byte_done  = fl[1];
    r.flag_rx_ready   = fl[0];
    r.rx_byte         = rx;
    return r;
  endfunction

  function automatic stim_row_t mk_row(in_item_t req, int cnt, out_item_t typed);
    stim_row_t s;
    s.req       = req;
    s.typed_cnt = cnt;
    s.typed     = typed;
    return s;
  endfunction

  function automatic in_item_t rand_req();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  function automatic logic hit(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Mostly well-formed transactions with random content, some noise mixed in.
  function automatic in_item_t next_req();
    in_item_t r;
    int       pick;
    r    = rand_req();
    pick = $urandom_range(0, 99);
    if (ph == PH_IDLE) begin
      if (pick < 35) begin
        r.cmd         = CMD_WRITE;
        r.data_amount = hit(15) ? 8'($urandom_range(64, 255)) : 8'($urandom_range(0, 63));
      end else if (pick < 75) begin
        r.cmd       = CMD_READ;
        r.read_type = 2'($urandom_range(0, 2));
        if (r.read_type == RT_SEQ)
          r.data_amount = hit(10) ? 8'($urandom_range(9, 255)) : 8'($urandom_range(0, 8));
        else
          r.data_amount = 8'($urandom_range(0, 1));
      end else if (pick < 85) begin
        r.cmd = CMD_READ;
        if (hit(50)) begin
          r.read_type = RT_BAD;
        end else begin
          r.read_type   = 2'($urandom_range(0, 1));
          r.data_amount = 8'($urandom_range(2, 255));
        end
      end
    end else if (ph == PH_W_NEED) begin
      if (pick < 85) r.cmd = CMD_BYTE;
    end else if (pick < 90) begin
      r.cmd             = CMD_TICK;
      r.flag_busy       = hit(12);
      r.flag_start_sent = !hit(12);
      r.flag_addr_acked = !hit(12);
      r.flag_byte_done  = !hit(12);
      r.flag_rx_ready   = !hit(12);
    end
    return r;
  endfunction

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return hit(73);
      IDLE_BOTH:   return hit(14);
      default:     return 1'b0;
    endcase
  endfunction

  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall_i = hit(73);
      IDLE_BOTH:     out_stall_i = hit(14);
      default:       out_stall_i = 1'b0;
    endcase
  end

  // Drives one request until accepted, then records what it should produce.
  task automatic send_req(stim_row_t row, output logic took);
    seq_phase_e  old_ph;
    logic [7:0]  old_ticks;
    @(negedge clk_i);
    while (sender_idles()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = row.req;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    old_ph    = ph;
    old_ticks = ticks_left;
    predict_actions(row.req);
    took = (step_q.size() != 0) || (ph != old_ph) || (ticks_left != old_ticks);
    if (row.typed_cnt < 0) begin
      foreach (step_q[i]) bus_q.push_back(step_q[i]);
    end else if (row.typed_cnt > 0) begin
      bus_q.push_back(row.typed);
    end
  endtask

  task automatic run_random(int n);
    stim_row_t row;
    logic      took;
    int        cnt;
    cnt = 0;
    while (cnt < n) begin
      row = mk_row(next_req(), -1, '0);
      send_req(row, took);
      if (took) cnt++;
    end
  endtask

  // Finish any open transaction with clean flags, then let the result queue empty.
  task automatic settle();
    stim_row_t row;
    in_item_t  r;
    logic      took;
    while (ph != PH_IDLE) begin
      r = rand_req();
      if (ph == PH_W_NEED) begin
        r.cmd = CMD_BYTE;
      end else begin
        r.cmd             = CMD_TICK;
        r.flag_busy       = 1'b0;
        r.flag_start_sent = 1'b1;
        r.flag_addr_acked = 1'b1;
        r.flag_byte_done  = 1'b1;
        r.flag_rx_ready   = 1'b1;
      end
      row = mk_row(r, -1, '0);
      send_req(row, took);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (bus_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_DEV_ADDR) dev_addr = val;
    else tmo_ticks = val;
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (bus_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 32'd0);
      end else begin
        want = bus_q.pop_front();
        if (got.action !== want.action)
          report_mismatch("action", 32'(got.action), 32'(want.action));
        if (got.tx_value !== want.tx_value)
          report_mismatch("tx_value", 32'(got.tx_value), 32'(want.tx_value));
        if (got.rx_data !== want.rx_data)
          report_mismatch("rx_data", 32'(got.rx_data), 32'(want.rx_data));
        if (got.protect_level !== want.protect_level)
          report_mismatch("protect_level", 32'(got.protect_level), 32'(want.protect_level));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    logic      took;
    out_item_t none;

    none        = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_DEV_ADDR;
    cfg_wdata_i = 8'd0;

    ph         = PH_IDLE;
    cur_addr   = '0;
    xfer_cnt   = '0;
    pages_left = '0;
    req_amt    = '0;
    rd_mode    = RT_CURRENT;
    ticks_left = '0;
    dev_addr   = DEV_ADDR_RST;
    tmo_ticks  = TIMEOUT_RST;

    // idle noise
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h7fff, 8'hff, RT_BAD, 8'hff, 5'b11111,
                                     8'hff), 0, none));
    dir_rows.push_back(mk_row(req_of(CMD_BYTE, 15'h0, 8'h0, RT_CURRENT, 8'hff, FL_NONE,
                                     8'h0), 0, none));
    // malformed reads
    dir_rows.push_back(mk_row(req_of(CMD_READ, 15'h0, 8'h0, RT_BAD, 8'h0, FL_NONE, 8'h0), 1,
                              bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_BADRQ, 1'b1)));
    dir_rows.push_back(mk_row(req_of(CMD_READ, 15'h0, 8'h2, RT_CURRENT, 8'h0, FL_NONE, 8'h0),
                              1, bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_BADRQ, 1'b1)));
    dir_rows.push_back(mk_row(req_of(CMD_READ, 15'h7fff, 8'hff, RT_RANDOM, 8'h0, FL_NONE,
                                     8'h0), 1,
                              bus_res(ACT_DONE, 8'd0, 8'd0, 1'b0, ST_BADRQ, 1'b1)));
    // single-byte current read
    dir_rows.push_back(mk_row(req_of(CMD_READ, 15'h7fff, 8'h1, RT_CURRENT, 8'h0, FL_NONE,
                                     8'h0), 0, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_BUSY, 8'h0),
                              0, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_NONE, 8'h0),
                              1, bus_res(ACT_START, 8'd0, 8'd0, 1'b0, ST_OK, 1'b1)));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_START, 8'h0),
                              1, bus_res(ACT_SEND, 8'ha1, 8'd0, 1'b0, ST_OK, 1'b1)));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_ADDR, 8'h0),
                              -1, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_RX, 8'hff),
                              -1, none));
    // zero-length write at the top address: wraps to zero after the first byte
    dir_rows.push_back(mk_row(req_of(CMD_WRITE, 15'h7fff, 8'h0, RT_CURRENT, 8'h0, FL_NONE,
                                     8'h0), 1,
                              bus_res(ACT_PROTECT, 8'd0, 8'd0, 1'b0, ST_OK, 1'b1)));
    dir_rows.push_back(mk_row(req_of(CMD_READ, 15'h1234, 8'h1, RT_RANDOM, 8'h0, FL_NONE,
                                     8'h0), 0, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_NONE, 8'h0),
                              -1, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_START, 8'h0),
                              -1, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_ADDR, 8'h0),
                              -1, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_BYTE, 8'h0),
                              -1, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_BYTE, 8'h0),
                              0, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_BYTE, 8'h0),
                              0, none));
    dir_rows.push_back(mk_row(req_of(CMD_BYTE, 15'h0, 8'h0, RT_CURRENT, 8'h00, FL_NONE, 8'h0),
                              -1, none));
    dir_rows.push_back(mk_row(req_of(CMD_BYTE, 15'h0, 8'h0, RT_CURRENT, 8'hff, FL_NONE, 8'h0),
                              0, none));
    dir_rows.push_back(mk_row(req_of(CMD_TICK, 15'h0, 8'h0, RT_CURRENT, 8'h0, FL_BYTE, 8'h0),
                              -1, none));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i], took);
    settle();

    run_random(70);
    settle();

    write_reg(CFG_DEV_ADDR, 8'd0);
    write_reg(CFG_TIMEOUT, 8'd0);
    idle_mode = IDLE_SENDER;
    run_random(70);
    settle();

    write_reg(CFG_DEV_ADDR, 8'd254);
    write_reg(CFG_TIMEOUT, 8'd255);
    idle_mode = IDLE_RECEIVER;
    run_random(70);
    settle();

    write_reg(CFG_DEV_ADDR, 8'($urandom_range(0, 254)));
    write_reg(CFG_TIMEOUT, 8'($urandom_range(1, 6)));
    idle_mode = IDLE_BOTH;
    run_random(70);
    settle();

    if (bus_q.size() != 0) report_mismatch("results never arrived", bus_q.size(), 32'd0);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
